// ----- design/bpfa_pkg.sv -----
package bpfa_pkg;

  localparam int MapWords  = 1024;
  localparam int AddrBits  = $clog2(MapWords);
  localparam int WordBits  = 64;
  localparam int BitBits   = $clog2(WordBits);
  localparam int CfgBits   = 11;
  localparam int PageBits  = 16;
  localparam int CountBits = 17;
  localparam int LimitBits = 17;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [AddrBits-1:0] addr_t;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_MARK  = 2'd2
  } cmd_e;

  // one-hot sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_ALLOC = 5'b00100,
    ST_FREE  = 5'b01000,
    ST_MARK  = 5'b10000
  } state_e;

endpackage

// ----- design/bitmap_page_frame_allocator_unit.sv -----
// channel   | signals                                              | direction
// ----------+------------------------------------------------------+----------
// command   | start, busy (out), command_i, page_number_i,       | in
//           | page_count_i, usable_i                               |
// result    | done_o, status_o, allocated_page_o                   | out
// config    | cfg_we_i, cfg_wdata_i (words_in_use)                 | in
//
// after reset a clearing pass writes all 1024 map words, one per cycle, with busy high.
// allocate reads the word at the hint, then scans one word per cycle until it finds a set bit or reaches words_in_use.
// free reads the page's word and writes it back; mark reads and rewrites each map word in its range.
// unknown commands and requests that touch no managed page finish from idle without reading the map.
// each cycle is bound by the single read port of the map RAM (read data registered).
// done_o is a one-cycle strobe; the receiver cannot stall, and a new command
// may be accepted while a result is still on the output.
module bitmap_page_frame_allocator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         command_i,
  input  logic [bpfa_pkg::PageBits-1:0]      page_number_i,
  input  logic [bpfa_pkg::CountBits-1:0]     page_count_i,
  input  logic                               usable_i,
  output logic                               done_o,
  output logic                               status_o,
  output logic [bpfa_pkg::PageBits-1:0]      allocated_page_o,
  input  logic                               cfg_we_i,
  input  logic [bpfa_pkg::CfgBits-1:0]       cfg_wdata_i
);
  import bpfa_pkg::*;

  word_t mem [MapWords];
  word_t rdata_q;

  state_e state_q, state_d;
  addr_t  hint_q, hint_d;
  addr_t  idx_q, idx_d;
  addr_t  clr_q, clr_d;
  logic [BitBits-1:0]   lo_q, lo_d;
  logic [BitBits-1:0]   bit_q, bit_d;
  logic [LimitBits-1:0] end_q, end_d;
  logic                 usable_q, usable_d;
  logic [CfgBits-1:0]   cfg_q;
  logic                 done_q, done_d;
  logic                 status_q, status_d;
  logic [PageBits-1:0]  page_q, page_d;

  logic  mem_we, mem_re;
  addr_t mem_waddr, mem_raddr;
  word_t mem_wdata;

  logic [CfgBits-1:0]     words;
  logic [LimitBits-1:0]   limit;
  logic [LimitBits:0]     range_sum;
  logic [LimitBits-1:0]   mark_end;
  logic [AddrBits:0]      idx_next;
  logic [LimitBits-1:0]   span;
  logic [BitBits:0]       hi;
  word_t                  mark_mask;
  word_t                  iso;
  logic [BitBits-1:0]     low_bit;
  addr_t                  page_word;

  // register above the map size acts as the full map
  assign words = (cfg_q > CfgBits'(MapWords)) ? CfgBits'(MapWords) : cfg_q;
  assign limit = {words, {BitBits{1'b0}}};
  assign page_word = page_number_i[PageBits-1:BitBits];

  assign range_sum = {2'b00, page_number_i} + {1'b0, page_count_i};
  assign mark_end  = (range_sum < {1'b0, limit}) ? range_sum[LimitBits-1:0] : limit;

  assign idx_next = {1'b0, idx_q} + (AddrBits+1)'(1);

  assign span = end_q - {1'b0, idx_q, {BitBits{1'b0}}};
  assign hi   = (span >= LimitBits'(WordBits)) ? (BitBits+1)'(WordBits) : span[BitBits:0];
  // bits lo..hi-1 of the current word
  assign mark_mask = ~({WordBits{1'b1}} << hi) & ({WordBits{1'b1}} << lo_q);

  // isolate the lowest set bit, then encode it
  assign iso = rdata_q & (~rdata_q + word_t'(1));
  always_comb begin
    low_bit = '0;
    for (int k = 0; k < WordBits; k++) begin
      if (iso[k]) begin
        low_bit = low_bit | BitBits'(k);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    hint_d    = hint_q;
    idx_d     = idx_q;
    clr_d     = clr_q;
    lo_d      = lo_q;
    bit_d     = bit_q;
    end_d     = end_q;
    usable_d  = usable_q;
    done_d    = 1'b0;
    status_d  = status_q;
    page_d    = page_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = idx_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + addr_t'(1);
        if (clr_q == addr_t'(MapWords - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          status_d = 1'b0;
          page_d   = '0;
          case (command_i)
            CMD_ALLOC: begin
              if ({1'b0, hint_q} < words) begin
                mem_re    = 1'b1;
                mem_raddr = hint_q;
                idx_d     = hint_q;
                state_d   = ST_ALLOC;
              end else begin
                status_d = 1'b1;
                done_d   = 1'b1;
              end
            end
            CMD_FREE: begin
              if ({1'b0, page_number_i} < limit) begin
                mem_re    = 1'b1;
                mem_raddr = page_word;
                idx_d     = page_word;
                bit_d     = page_number_i[BitBits-1:0];
                state_d   = ST_FREE;
                if (page_word < hint_q) begin
                  hint_d = page_word;
                end
              end else begin
                done_d = 1'b1;
              end
            end
            CMD_MARK: begin
              if ({1'b0, page_number_i} < mark_end) begin
                mem_re    = 1'b1;
                mem_raddr = page_word;
                idx_d     = page_word;
                lo_d      = page_number_i[BitBits-1:0];
                end_d     = mark_end;
                usable_d  = usable_i;
                state_d   = ST_MARK;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_ALLOC: begin
        if (rdata_q != '0) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q & (rdata_q - word_t'(1));
          hint_d    = idx_q;
          page_d    = {idx_q, low_bit};
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end else if (idx_next < words) begin
          // keep scanning, one word per cycle
          mem_re    = 1'b1;
          mem_raddr = idx_next[AddrBits-1:0];
          idx_d     = idx_next[AddrBits-1:0];
        end else begin
          status_d = 1'b1;
          done_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_FREE: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q | (word_t'(1) << bit_q);
        done_d    = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = usable_q ? (rdata_q | mark_mask) : (rdata_q & ~mark_mask);
        // next word read overlaps this write, different address
        if ({idx_next, {BitBits{1'b0}}} < end_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_next[AddrBits-1:0];
          idx_d     = idx_next[AddrBits-1:0];
          lo_d      = '0;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      hint_q  <= '0;
      clr_q   <= '0;
      cfg_q   <= CfgBits'(MapWords);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hint_q  <= hint_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    lo_q     <= lo_d;
    bit_q    <= bit_d;
    end_q    <= end_d;
    usable_q <= usable_d;
    status_q <= status_d;
    page_q   <= page_d;
  end

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign allocated_page_o = page_q;

endmodule
